FILE: design/drfl_pkg.sv
`timescale 1ns / 1ps
package drfl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int FRAC_BITS   = 12;
  localparam int AMT_W       = 48;
  localparam int LIM_W       = 47;
  localparam int YEAR_W      = 14;
  localparam int MD_W        = 7;
  localparam int KEY_W       = YEAR_W + 2 * MD_W;
  localparam int WORD_W      = KEY_W + AMT_W;
  localparam int PROD_W      = 64;
  localparam int HALF_W      = AMT_W / 2;
  localparam int ACC_W       = 2 * AMT_W;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4096000);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STORED    = 3'd1,
    ST_BAD_DATE  = 3'd2,
    ST_NEGATIVE  = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_TOO_EARLY = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef struct packed {
    logic    load;
    logic    init;
    logic    cmp;
    logic    wr_pos;
    logic    inc_cnt;
    logic    sh_rd;
    logic    sh_wr;
    logic    mul_start;
    logic    mul_step;
    logic    set_res;
    status_t res;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic    is_query;
    logic    pre_bad;
    status_t pre_code;
    logic    search_done;
    logic    match;
    logic    full;
    logic    early;
    logic    shift_done;
    logic    mul_done;
    logic    out_free;
  } stat_t;

  function automatic logic [4:0] month_len(input logic [MD_W-1:0] m);
    logic [4:0] len;
    case (m)
      7'd2:                      len = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: design/drfl_in_if.sv
`timescale 1ns / 1ps
interface drfl_in_if import drfl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [YEAR_W-1:0]        year;
  logic [MD_W-1:0]          month;
  logic [MD_W-1:0]          day;
  logic signed [AMT_W-1:0]  amount;

  modport source (output valid, kind, year, month, day, amount, input ready);
  modport sink   (input valid, kind, year, month, day, amount, output ready);
endinterface

FILE: design/drfl_out_if.sv
`timescale 1ns / 1ps
interface drfl_out_if import drfl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [PROD_W-1:0] product;

  modport source (output valid, status, product, input ready);
  modport sink   (input valid, status, product, output ready);
endinterface

FILE: design/dated_rate_floor_lookup_unit.sv
`timescale 1ns / 1ps
// Dated rate table with floor lookup.
// in_ch carries load items (kind 0: insert or overwrite a date/rate entry)
// and query items (kind 1: check date and value, find the latest entry on
// or before the date, return value times rate, 12 fraction bits, saturated).
// out_ch returns one item per input item: status and product.
// cfg_we/cfg_wdata write the value limit; write only while idle.
// One item at a time. Each search step reads the registered-read table
// memory (ceil(log2(entries+1)) steps); a query rejected on its date or
// value does no search; queries that find an entry then run the four-part
// multiply; inserts of a new date move each entry above the insert point
// up one place (a read and a write per entry) before writing the new one.
// Reset empties the table (entry count to zero) and restores the limit
// to 1000.0; no clearing pass is needed.
// A finished result waits in the output register while the next item is
// taken and worked on; if that one finishes before the receiver takes the
// first, the block holds until the output register frees.
module dated_rate_floor_lookup_unit import drfl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata,
  drfl_in_if.sink          in_ch,
  drfl_out_if.source       out_ch
);
  cmd_t  cmd;
  stat_t st;

  drfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  drfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .st        (st)
  );
endmodule

FILE: design/drfl_ram.sv
`timescale 1ns / 1ps
module drfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/drfl_dp.sv
`timescale 1ns / 1ps
module drfl_dp import drfl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIM_W-1:0]   cfg_wdata,
  drfl_in_if.sink            in_ch,
  drfl_out_if.source         out_ch,
  input  cmd_t               cmd,
  output stat_t              st
);
  logic              kind_r;
  logic [YEAR_W-1:0] year_r;
  logic [MD_W-1:0]   month_r, day_r;
  logic [AMT_W-1:0]  amt_r;
  logic [LIM_W-1:0]  limit_r;
  logic [CNT_W-1:0]  lo_r, hi_r, idx_r, cnt_r;
  logic              eq_r;
  logic [AMT_W-1:0]  rate_r;
  logic [AMT_W-1:0]  pp_r;
  logic [1:0]        sel_r;
  logic [2:0]        step_r;
  logic [ACC_W-1:0]  acc_r;
  status_t           res_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [PROD_W-1:0] out_product_r;

  logic [KEY_W-1:0]  key;
  logic [CNT_W-1:0]  mid;
  logic [WORD_W-1:0] rdata, wdata;
  logic [KEY_W-1:0]  key_m;
  logic              go_right, we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [26:0]       q_full;
  logic [9:0]        q25;
  logic [YEAR_W-1:0] rem25;
  logic              leap, date_ok;
  logic [4:0]        mlen;
  logic [HALF_W-1:0] pa, pb;
  logic [ACC_W-1:0]  pp_sh;
  logic              sat;
  logic [PROD_W-1:0] prod;

  assign key   = {year_r, month_r, day_r};
  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign key_m = rdata[WORD_W-1:AMT_W];
  assign go_right = kind_r ? (key_m <= key) : (key_m < key);

  // year mod 25 by reciprocal multiply
  assign q_full = 27'(year_r) * 27'd5243;
  assign q25    = q_full[26:17];
  assign rem25  = year_r - (YEAR_W'(q25) * YEAR_W'(25));
  assign leap   = (year_r[1:0] == 2'd0) && ((rem25 != '0) || (year_r[3:0] == 4'd0));
  assign mlen   = (leap && month_r == 7'd2) ? 5'd29 : month_len(month_r);
  assign date_ok = (month_r >= 7'd1) && (month_r <= 7'd12) && (day_r >= 7'd1)
                   && (day_r <= MD_W'(mlen));

  assign raddr = cmd.sh_rd ? ADDR_W'(idx_r - 1'b1) : mid[ADDR_W-1:0];
  assign we    = cmd.sh_wr | cmd.wr_pos;
  assign waddr = cmd.sh_wr ? idx_r[ADDR_W-1:0] : lo_r[ADDR_W-1:0];
  assign wdata = cmd.sh_wr ? rdata : {key, amt_r};

  drfl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (step_r[1:0])
      2'd0:    begin pa = amt_r[HALF_W-1:0];     pb = rate_r[HALF_W-1:0];     end
      2'd1:    begin pa = amt_r[HALF_W-1:0];     pb = rate_r[AMT_W-1:HALF_W]; end
      2'd2:    begin pa = amt_r[AMT_W-1:HALF_W]; pb = rate_r[HALF_W-1:0];     end
      default: begin pa = amt_r[AMT_W-1:HALF_W]; pb = rate_r[AMT_W-1:HALF_W]; end
    endcase
    case (sel_r)
      2'd0:    pp_sh = ACC_W'(pp_r);
      2'd3:    pp_sh = ACC_W'(pp_r) << (2 * HALF_W);
      default: pp_sh = ACC_W'(pp_r) << HALF_W;
    endcase
  end

  assign sat  = |acc_r[ACC_W-1:FRAC_BITS+PROD_W-1];
  assign prod = sat ? {1'b0, {(PROD_W-1){1'b1}}}
                    : {1'b0, acc_r[FRAC_BITS+PROD_W-2:FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_ch.kind;
      year_r  <= in_ch.year;
      month_r <= in_ch.month;
      day_r   <= in_ch.day;
      amt_r   <= in_ch.amount;
    end
    if (cmd.init) begin
      lo_r  <= '0;
      hi_r  <= cnt_r;
      idx_r <= cnt_r;
      eq_r  <= 1'b0;
    end
    if (cmd.cmp) begin
      if (go_right) begin
        lo_r   <= mid + 1'b1;
        rate_r <= rdata[AMT_W-1:0];
      end else begin
        hi_r <= mid;
        eq_r <= (key_m == key);
      end
    end
    if (cmd.sh_wr) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.mul_start) begin
      step_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.mul_step) begin
      step_r <= step_r + 1'b1;
      if (step_r < 3'd4) begin
        pp_r  <= pa * pb;
        sel_r <= step_r[1:0];
      end
      if (step_r != 3'd0) begin
        acc_r <= acc_r + pp_sh;
      end
    end
    if (cmd.set_res) begin
      res_r <= cmd.res;
    end
    if (cmd.out_load) begin
      out_status_r  <= res_r;
      out_product_r <= (res_r == ST_OK) ? prod : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.inc_cnt) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.is_query    = kind_r;
    st.pre_bad     = !date_ok || amt_r[AMT_W-1] || (amt_r > AMT_W'(limit_r));
    st.pre_code    = !date_ok ? ST_BAD_DATE : (amt_r[AMT_W-1] ? ST_NEGATIVE : ST_TOO_LARGE);
    st.search_done = (lo_r >= hi_r);
    st.match       = eq_r;
    st.full        = (cnt_r >= CNT_W'(TABLE_DEPTH));
    st.early       = (lo_r == '0) || rate_r[AMT_W-1];
    st.shift_done  = (idx_r == lo_r);
    st.mul_done    = (step_r == 3'd5);
    st.out_free    = !out_valid_r || out_ch.ready;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.product = out_product_r;
endmodule

FILE: design/drfl_ctrl.sv
`timescale 1ns / 1ps
module drfl_ctrl import drfl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_RD    = 8'b00000100,
    S_CMP   = 8'b00001000,
    S_SHRD  = 8'b00010000,
    S_SHWR  = 8'b00100000,
    S_MUL   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.is_query && st.pre_bad) begin
          cmd.set_res = 1'b1;
          cmd.res     = st.pre_code;
          state_nxt   = S_DONE;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (!st.search_done) begin
          state_nxt = S_CMP;
        end else if (st.is_query) begin
          if (st.early) begin
            cmd.set_res = 1'b1;
            cmd.res     = ST_TOO_EARLY;
            state_nxt   = S_DONE;
          end else begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end
        end else if (st.match) begin
          cmd.wr_pos  = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res     = ST_STORED;
          state_nxt   = S_DONE;
        end else if (st.full) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_RD;
      end
      S_SHRD: begin
        if (st.shift_done) begin
          cmd.wr_pos  = 1'b1;
          cmd.inc_cnt = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res     = ST_STORED;
          state_nxt   = S_DONE;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_MUL: begin
        if (st.mul_done) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_OK;
          state_nxt   = S_DONE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
